[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the triangle normal checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define TNC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tnc assertion failed");

// check that a condition implies a consequence in the next cycle
`define TNC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tnc assertion failed");

`endif

[src/tnc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnc_pkg
// Types, constants and helpers of the triangle normal checker.
// ----------------------------------------------------------------------------
package tnc_pkg;

  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 31;

  localparam logic [30:0] ZERO_LIMIT_RST  = 31'd10737;
  localparam logic [30:0] ALIGN_LIMIT_RST = 31'd10737;

  localparam logic ADDR_ZERO_LIMIT  = 1'b0;
  localparam logic ADDR_ALIGN_LIMIT = 1'b1;

  typedef logic signed [31:0] vertex_t;
  typedef logic signed [32:0] edge_t;
  typedef logic signed [30:0] sedge_t;
  typedef logic signed [61:0] prod_t;
  typedef logic signed [62:0] cross_t;
  typedef logic        [61:0] mag_t;
  typedef logic        [30:0] norm_t;
  typedef logic signed [31:0] unit_t;

  typedef struct packed {
    logic signed [31:0] normal_in_x;
    logic signed [31:0] normal_in_y;
    logic signed [31:0] normal_in_z;
    logic signed [31:0] vertex0_x;
    logic signed [31:0] vertex0_y;
    logic signed [31:0] vertex0_z;
    logic signed [31:0] vertex1_x;
    logic signed [31:0] vertex1_y;
    logic signed [31:0] vertex1_z;
    logic signed [31:0] vertex2_x;
    logic signed [31:0] vertex2_y;
    logic signed [31:0] vertex2_z;
  } tnc_in_t;

  typedef struct packed {
    logic signed [31:0] normal_out_x;
    logic signed [31:0] normal_out_y;
    logic signed [31:0] normal_out_z;
    logic               normal_was_set;
    logic               winding_reversed;
    logic               still_mismatched;
  } tnc_out_t;

  function automatic logic [5:0] lzc62(logic [61:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 62; i++) begin
      if (v[i]) n = 6'(61 - i);
    end
    return n;
  endfunction

endpackage

[src/tnc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnc_in_if / tnc_out_if
// Valid/ready channels carrying triangle requests and checked normals.
// ----------------------------------------------------------------------------
interface tnc_in_if import tnc_pkg::*; ();
  logic    valid;
  logic    ready;
  tnc_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tnc_out_if import tnc_pkg::*; ();
  logic     valid;
  logic     ready;
  tnc_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/tnc_face_normal.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnc_face_normal
// Four-stage cross product of the scaled edges b-a and c-a.
// ----------------------------------------------------------------------------
module tnc_face_normal import tnc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    vld_i,
  input  vertex_t a_i [3],
  input  vertex_t b_i [3],
  input  vertex_t c_i [3],
  output logic    vld_o,
  output cross_t  n_o [3]
);

  logic   v1_q, v2_q, v3_q, v4_q;
  edge_t  e1_q [3];
  edge_t  e2_q [3];
  sedge_t s1_q [3];
  sedge_t s2_q [3];
  prod_t  p_q  [6];
  cross_t n_q  [3];

  logic   fit1_0, fit1_1, fit2_0, fit2_1;
  sedge_t s1_d [3];
  sedge_t s2_d [3];

  always_comb begin
    fit1_0 = 1'b1;
    fit1_1 = 1'b1;
    fit2_0 = 1'b1;
    fit2_1 = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (!(e1_q[i][32:30] == 3'b000 || e1_q[i][32:30] == 3'b111)) fit1_0 = 1'b0;
      if (e1_q[i][32] != e1_q[i][31]) fit1_1 = 1'b0;
      if (!(e2_q[i][32:30] == 3'b000 || e2_q[i][32:30] == 3'b111)) fit2_0 = 1'b0;
      if (e2_q[i][32] != e2_q[i][31]) fit2_1 = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      if (fit1_0)      s1_d[i] = e1_q[i][30:0];
      else if (fit1_1) s1_d[i] = e1_q[i][31:1];
      else             s1_d[i] = e1_q[i][32:2];
      if (fit2_0)      s2_d[i] = e2_q[i][30:0];
      else if (fit2_1) s2_d[i] = e2_q[i][31:1];
      else             s2_d[i] = e2_q[i][32:2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= edge_t'(b_i[i]) - edge_t'(a_i[i]);
        e2_q[i] <= edge_t'(c_i[i]) - edge_t'(a_i[i]);
        s1_q[i] <= s1_d[i];
        s2_q[i] <= s2_d[i];
      end
      p_q[0] <= s1_q[1] * s2_q[2];
      p_q[1] <= s1_q[2] * s2_q[1];
      p_q[2] <= s1_q[2] * s2_q[0];
      p_q[3] <= s1_q[0] * s2_q[2];
      p_q[4] <= s1_q[0] * s2_q[1];
      p_q[5] <= s1_q[1] * s2_q[0];
      for (int i = 0; i < 3; i++) begin
        n_q[i] <= cross_t'(p_q[2*i]) - cross_t'(p_q[2*i+1]);
      end
    end
  end

  assign vld_o = v4_q;
  assign n_o   = n_q;

endmodule

[src/tnc_unit_vec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnc_unit_vec
// Pipelined normalizer: magnitude, leading-one align, sum of squares,
// digit-by-digit square root, and three radix-2 dividers.
// ----------------------------------------------------------------------------
module tnc_unit_vec import tnc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   vld_i,
  input  cross_t c_i [3],
  output logic   vld_o,
  output unit_t  u_o [3]
);

  // front stages
  logic       v1_q, v2_q, v3_q, v4_q;
  mag_t       m1_q [3];
  mag_t       m2_q [3];
  logic [2:0] sg1_q, sg2_q, sg3_q, sg4_q;
  logic [5:0] lz2_q;
  logic       z2_q, z3_q, z4_q;
  norm_t      n3_q [3];
  norm_t      n4_q [3];
  logic [61:0] sq4_q [3];
  mag_t       sh3_d [3];

  // square root stages
  logic [63:0] sx_q    [SQ_STEPS+1];
  logic [33:0] srem_q  [SQ_STEPS+1];
  logic [31:0] sroot_q [SQ_STEPS+1];
  norm_t       sn_q    [SQ_STEPS+1][3];
  logic [2:0]  ssg_q   [SQ_STEPS+1];
  logic        sz_q    [SQ_STEPS+1];
  logic        sv_q    [SQ_STEPS+1];

  // divider stages
  logic [31:0] dlen_q [DIV_STEPS+1];
  logic [31:0] drem_q [DIV_STEPS+1][3];
  logic [30:0] dlow_q [DIV_STEPS+1][3];
  logic [30:0] dq_q   [DIV_STEPS+1][3];
  logic [2:0]  dsg_q  [DIV_STEPS+1];
  logic        dz_q   [DIV_STEPS+1];
  logic        dv_q   [DIV_STEPS+1];

  logic [61:0] num_d [3];
  logic        vo_q;
  unit_t       u_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh3_d[i] = m2_q[i] << lz2_q;
      num_d[i] = {1'b0, sn_q[SQ_STEPS][i], 30'b0} + {31'b0, sroot_q[SQ_STEPS][31:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      sv_q[0]  <= 1'b0;
      dv_q[0]  <= 1'b0;
      vo_q     <= 1'b0;
    end else if (en_i) begin
      v1_q     <= vld_i;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      sv_q[0]  <= v4_q;
      dv_q[0]  <= sv_q[SQ_STEPS];
      vo_q     <= dv_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sg1_q[i] <= c_i[i][62];
        m1_q[i]  <= c_i[i][62] ? mag_t'(-c_i[i]) : mag_t'(c_i[i]);
      end
      m2_q  <= m1_q;
      sg2_q <= sg1_q;
      lz2_q <= lzc62(m1_q[0] | m1_q[1] | m1_q[2]);
      z2_q  <= ~|(m1_q[0] | m1_q[1] | m1_q[2]);
      for (int i = 0; i < 3; i++) begin
        n3_q[i]  <= sh3_d[i][61:31];
        sq4_q[i] <= n3_q[i] * n3_q[i];
      end
      sg3_q <= sg2_q;
      z3_q  <= z2_q;
      n4_q  <= n3_q;
      sg4_q <= sg3_q;
      z4_q  <= z3_q;
      sx_q[0]    <= {2'b0, sq4_q[0]} + {2'b0, sq4_q[1]} + {2'b0, sq4_q[2]};
      srem_q[0]  <= '0;
      sroot_q[0] <= '0;
      sn_q[0]    <= n4_q;
      ssg_q[0]   <= sg4_q;
      sz_q[0]    <= z4_q;
      dlen_q[0]  <= sroot_q[SQ_STEPS];
      for (int i = 0; i < 3; i++) begin
        drem_q[0][i] <= {1'b0, num_d[i][61:31]};
        dlow_q[0][i] <= num_d[i][30:0];
        dq_q[0][i]   <= '0;
      end
      dsg_q[0] <= ssg_q[SQ_STEPS];
      dz_q[0]  <= sz_q[SQ_STEPS];
      for (int i = 0; i < 3; i++) begin
        if (dz_q[DIV_STEPS])          u_q[i] <= '0;
        else if (dsg_q[DIV_STEPS][i]) u_q[i] <= -unit_t'({1'b0, dq_q[DIV_STEPS][i]});
        else                          u_q[i] <= unit_t'({1'b0, dq_q[DIV_STEPS][i]});
      end
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam int J = SQ_STEPS - 1 - k;
    logic [35:0] r2;
    logic [35:0] trial;
    logic        ge;
    always_comb begin
      r2    = {srem_q[k], sx_q[k][2*J+1 -: 2]};
      trial = {2'b0, sroot_q[k], 2'b01};
      ge    = (r2 >= trial);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else if (en_i) begin
        sv_q[k+1] <= sv_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        srem_q[k+1]  <= ge ? 34'(r2 - trial) : r2[33:0];
        sroot_q[k+1] <= {sroot_q[k][30:0], ge};
        sx_q[k+1]    <= sx_q[k];
        sn_q[k+1]    <= sn_q[k];
        ssg_q[k+1]   <= ssg_q[k];
        sz_q[k+1]    <= sz_q[k];
      end
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int B = DIV_STEPS - 1 - k;
    logic [32:0] r   [3];
    logic        ge  [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r[i]  = {drem_q[k][i], dlow_q[k][i][B]};
        ge[i] = (r[i] >= {1'b0, dlen_q[k]});
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (en_i) begin
        dv_q[k+1] <= dv_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          drem_q[k+1][i] <= ge[i] ? 32'(r[i] - {1'b0, dlen_q[k]}) : r[i][31:0];
          dq_q[k+1][i]   <= {dq_q[k][i][29:0], ge[i]};
          dlow_q[k+1][i] <= dlow_q[k][i];
        end
        dlen_q[k+1] <= dlen_q[k];
        dsg_q[k+1]  <= dsg_q[k];
        dz_q[k+1]   <= dz_q[k];
      end
    end
  end

  assign vld_o = vo_q;
  assign u_o   = u_q;

endmodule

[src/tnc_judge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnc_judge
// Dot products against the limits, flag logic and the output register.
// ----------------------------------------------------------------------------
module tnc_judge import tnc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  unit_t       nst_i [3],
  input  unit_t       nc_i  [3],
  input  unit_t       nr_i  [3],
  input  logic [30:0] zero_limit_i,
  input  logic [30:0] align_limit_i,
  output logic        vld_o,
  output tnc_out_t    res_o
);

  localparam logic signed [34:0] OneQ30 = 35'sd1073741824;

  logic               v1_q, v2_q, v3_q;
  logic signed [63:0] pss_q [3];
  logic signed [63:0] psc_q [3];
  logic signed [63:0] psr_q [3];
  unit_t              nst1_q [3];
  unit_t              nc1_q  [3];
  unit_t              nst2_q [3];
  unit_t              nc2_q  [3];
  logic               set_q, mc_q, mr_q;
  tnc_out_t           res_q;

  logic signed [63:0] sum_ss, sum_sc, sum_sr;
  logic signed [34:0] dc, dr, ac, ar;
  logic               set_d, mc_d, mr_d, rev_d;

  always_comb begin
    sum_ss = pss_q[0] + pss_q[1] + pss_q[2];
    sum_sc = psc_q[0] + psc_q[1] + psc_q[2];
    sum_sr = psr_q[0] + psr_q[1] + psr_q[2];
    set_d  = (sum_ss[63:30] < {3'b0, zero_limit_i});
    dc     = {sum_sc[63], sum_sc[63:30]} - OneQ30;
    dr     = {sum_sr[63], sum_sr[63:30]} - OneQ30;
    ac     = dc[34] ? -dc : dc;
    ar     = dr[34] ? -dr : dr;
    mc_d   = ($unsigned(ac) > {4'b0, align_limit_i});
    mr_d   = ($unsigned(ar) > {4'b0, align_limit_i});
    rev_d  = !set_q && mc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        pss_q[i] <= nst_i[i] * nst_i[i];
        psc_q[i] <= nst_i[i] * nc_i[i];
        psr_q[i] <= nst_i[i] * nr_i[i];
      end
      nst1_q <= nst_i;
      nc1_q  <= nc_i;
      nst2_q <= nst1_q;
      nc2_q  <= nc1_q;
      set_q  <= set_d;
      mc_q   <= mc_d;
      mr_q   <= mr_d;
      res_q.normal_out_x     <= set_q ? nc2_q[0] : nst2_q[0];
      res_q.normal_out_y     <= set_q ? nc2_q[1] : nst2_q[1];
      res_q.normal_out_z     <= set_q ? nc2_q[2] : nst2_q[2];
      res_q.normal_was_set   <= set_q;
      res_q.winding_reversed <= rev_d;
      res_q.still_mismatched <= rev_d && mr_q;
    end
  end

  assign vld_o = v3_q;
  assign res_o = res_q;

endmodule

[src/triangle_normal_checker_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_normal_checker_unit
// Face normal check of mesh triangles against their stored normals.
// ----------------------------------------------------------------------------
// Takes one triangle request per clock unless stalled and returns its result
// after edge scaling and cross product, the normalizers (5 align and square
// stages, 32 square root digits, one divider setup, 31 quotient bits, one
// sign stage) and the dot products and flags. All stages advance together;
// the pipeline holds only while a result waits in the output register, so
// the sustained rate is one item per cycle while results are taken.
// Limits are written over the register port at byte addresses 0 and 4.
`include "assert_macros.svh"

module triangle_normal_checker_unit import tnc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  tnc_in_if.sink      in_i,
  tnc_out_if.source   out_o
);

  logic [30:0] zero_limit_q, align_limit_q;
  logic        en;
  vertex_t     v0 [3];
  vertex_t     v1 [3];
  vertex_t     v2 [3];
  vertex_t     nin [3];
  vertex_t     nd_q [4][3];
  cross_t      nin_ext [3];
  cross_t      cf [3];
  cross_t      cr [3];
  logic        vf, vr, vuf, vur, vus;
  unit_t       uf [3];
  unit_t       ur [3];
  unit_t       us [3];
  logic        out_vld;
  tnc_out_t    res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_ALIGN_LIMIT) ? {1'b0, align_limit_q} : {1'b0, zero_limit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_limit_q  <= ZERO_LIMIT_RST;
      align_limit_q <= ALIGN_LIMIT_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        ADDR_ZERO_LIMIT:  zero_limit_q  <= pwdata[30:0];
        ADDR_ALIGN_LIMIT: align_limit_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  assign en         = !out_vld || out_o.ready;
  assign in_i.ready = en;

  assign v0  = '{in_i.data.vertex0_x, in_i.data.vertex0_y, in_i.data.vertex0_z};
  assign v1  = '{in_i.data.vertex1_x, in_i.data.vertex1_y, in_i.data.vertex1_z};
  assign v2  = '{in_i.data.vertex2_x, in_i.data.vertex2_y, in_i.data.vertex2_z};
  assign nin = '{in_i.data.normal_in_x, in_i.data.normal_in_y, in_i.data.normal_in_z};

  always_ff @(posedge clk_i) begin
    if (en) begin
      nd_q[0] <= nin;
      for (int k = 1; k < 4; k++) nd_q[k] <= nd_q[k-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) nin_ext[i] = {{31{nd_q[3][i][31]}}, nd_q[3][i]};
  end

  tnc_face_normal u_face_fwd (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_i.valid),
    .a_i(v0), .b_i(v1), .c_i(v2), .vld_o(vf), .n_o(cf)
  );

  tnc_face_normal u_face_rev (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_i.valid),
    .a_i(v2), .b_i(v1), .c_i(v0), .vld_o(vr), .n_o(cr)
  );

  tnc_unit_vec u_unit_fwd (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vf), .c_i(cf), .vld_o(vuf), .u_o(uf)
  );

  tnc_unit_vec u_unit_rev (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vr), .c_i(cr), .vld_o(vur), .u_o(ur)
  );

  tnc_unit_vec u_unit_nin (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vf), .c_i(nin_ext), .vld_o(vus), .u_o(us)
  );

  tnc_judge u_judge (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vuf && vur && vus),
    .nst_i(us), .nc_i(uf), .nr_i(ur),
    .zero_limit_i(zero_limit_q), .align_limit_i(align_limit_q),
    .vld_o(out_vld), .res_o(res)
  );

  assign out_o.valid = out_vld;
  assign out_o.data  = res;

  `TNC_ASSERT(a_mis_needs_rev, clk_i, rst_ni, (out_o.valid && out_o.data.still_mismatched) |-> out_o.data.winding_reversed)
  `TNC_ASSERT(a_set_not_rev, clk_i, rst_ni, (out_o.valid && out_o.data.normal_was_set) |-> !out_o.data.winding_reversed)
  `TNC_ASSERT(a_stall_blocks_in, clk_i, rst_ni, (out_o.valid && !out_o.ready) |-> !in_i.ready)
  `TNC_ASSERT_NEXT(a_zero_limit_wr, clk_i, rst_ni, (psel && penable && pwrite && !paddr[2]), zero_limit_q == $past(pwdata[30:0]))

endmodule

[tb/triangle_normal_checker_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_normal_checker_unit_tb
// Self-checking bench for the triangle face normal checker.
// Drives triangle requests with random content and stalls on both channels,
// predicts every checked normal and its flags in fixed point, and compares
// each returned result with the oldest prediction. Limits are reprogrammed
// between phases over the register port.
// ----------------------------------------------------------------------------
module triangle_normal_checker_unit_tb;
  import tnc_pkg::*;

  typedef longint vec3_t [3];

  localparam longint ONE_Q30  = 64'sd1 << 30;
  localparam int     WD_LIMIT = 5000;

  class normal_scoreboard;
    tnc_out_t        pending[$];
    longint unsigned zero_lim;
    longint unsigned align_lim;
    int              errors;

    function new();
      zero_lim  = ZERO_LIMIT_RST;
      align_lim = ALIGN_LIMIT_RST;
      errors    = 0;
    endfunction

    function void set_limit(logic reg_sel, logic [31:0] value);
      if (reg_sel == ADDR_ZERO_LIMIT) zero_lim = value[30:0];
      else align_lim = value[30:0];
    endfunction

    function longint unsigned isqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function vec3_t scale_edge(vec3_t e);
      int     s;
      longint lim;
      bit     fits;
      vec3_t  o;
      s = 0;
      while (s < 2) begin
        lim  = 64'sd1 << (30 + s);
        fits = 1;
        for (int i = 0; i < 3; i++) if (e[i] < -lim || e[i] >= lim) fits = 0;
        if (fits) break;
        s++;
      end
      for (int i = 0; i < 3; i++) o[i] = e[i] >>> s;
      return o;
    endfunction

    function vec3_t to_unit(vec3_t c);
      longint unsigned m[3], mx, sum, len, q;
      vec3_t           o;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = c[i] < 0 ? longint'(-c[i]) : longint'(c[i]);
        if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) return '{0, 0, 0};
      while (mx >= (64'd1 << 31)) begin
        for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        mx = mx >> 1;
      end
      while (mx < (64'd1 << 30)) begin
        for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        mx = mx << 1;
      end
      sum = 0;
      for (int i = 0; i < 3; i++) sum += m[i] * m[i];
      len = isqrt(sum);
      for (int i = 0; i < 3; i++) begin
        q    = ((m[i] << 30) + (len >> 1)) / len;
        o[i] = c[i] < 0 ? -longint'(q) : longint'(q);
      end
      return o;
    endfunction

    function vec3_t face_normal(vec3_t a, vec3_t b, vec3_t c);
      vec3_t e1, e2, x;
      for (int i = 0; i < 3; i++) begin
        e1[i] = b[i] - a[i];
        e2[i] = c[i] - a[i];
      end
      e1 = scale_edge(e1);
      e2 = scale_edge(e2);
      x[0] = e1[1] * e2[2] - e1[2] * e2[1];
      x[1] = e1[2] * e2[0] - e1[0] * e2[2];
      x[2] = e1[0] * e2[1] - e1[1] * e2[0];
      return to_unit(x);
    endfunction

    function longint dot_q30(vec3_t a, vec3_t b);
      return (a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> 30;
    endfunction

    function bit misaligned(vec3_t a, vec3_t b);
      longint d;
      d = dot_q30(a, b) - ONE_Q30;
      if (d < 0) d = -d;
      return longint'(d) > longint'(align_lim);
    endfunction

    function void note_request(tnc_in_t r);
      vec3_t    nin, v0, v1, v2, nst, ncomp, res;
      tnc_out_t e;
      nin = '{longint'(r.normal_in_x), longint'(r.normal_in_y), longint'(r.normal_in_z)};
      v0  = '{longint'(r.vertex0_x), longint'(r.vertex0_y), longint'(r.vertex0_z)};
      v1  = '{longint'(r.vertex1_x), longint'(r.vertex1_y), longint'(r.vertex1_z)};
      v2  = '{longint'(r.vertex2_x), longint'(r.vertex2_y), longint'(r.vertex2_z)};
      ncomp = face_normal(v0, v1, v2);
      nst   = to_unit(nin);
      res   = nst;
      e     = '0;
      if (longint'(dot_q30(nst, nst)) < longint'(zero_lim)) begin
        e.normal_was_set = 1'b1;
        res = ncomp;
      end else if (misaligned(nst, ncomp)) begin
        e.winding_reversed = 1'b1;
        e.still_mismatched = misaligned(nst, face_normal(v2, v1, v0));
      end
      e.normal_out_x = res[0][31:0];
      e.normal_out_y = res[1][31:0];
      e.normal_out_z = res[2][31:0];
      pending = {pending, e};
    endfunction

    task report(string what, logic [31:0] exp_v, logic [31:0] got_v);
      $display("ERROR %0t: %s expected %h got %h", $realtime, what, exp_v, got_v);
      errors++;
    endtask

    task check_result(tnc_out_t g);
      tnc_out_t e;
      if (pending.size() == 0) begin
        report("unexpected result", '0, g.normal_out_x);
        return;
      end
      e = pending.pop_front();
      if (g.normal_out_x !== e.normal_out_x) report("normal_out_x", e.normal_out_x, g.normal_out_x);
      if (g.normal_out_y !== e.normal_out_y) report("normal_out_y", e.normal_out_y, g.normal_out_y);
      if (g.normal_out_z !== e.normal_out_z) report("normal_out_z", e.normal_out_z, g.normal_out_z);
      if (g.normal_was_set !== e.normal_was_set)
        report("normal_was_set", e.normal_was_set, g.normal_was_set);
      if (g.winding_reversed !== e.winding_reversed)
        report("winding_reversed", e.winding_reversed, g.winding_reversed);
      if (g.still_mismatched !== e.still_mismatched)
        report("still_mismatched", e.still_mismatched, g.still_mismatched);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  int          send_idle, recv_idle, stall_cnt;

  tnc_in_if  in_if ();
  tnc_out_if out_if ();

  normal_scoreboard sb = new();

  triangle_normal_checker_unit dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_if.ready = rst_n && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_request(in_if.data);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cnt = 0;
      end else begin
        stall_cnt++;
        if (stall_cnt >= WD_LIMIT) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  task write_limit(logic reg_sel, logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {reg_sel, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_limit(reg_sel, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task send_request(tnc_in_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.data  = r;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function int rand_coord();
    return int'($urandom) >>> $urandom_range(0, 24);
  endfunction

  function tnc_in_t build_triangle();
    tnc_in_t r;
    vec3_t   a, b, c, n;
    int      pick;
    pick = $urandom_range(99);
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (pick >= 90) return r;
    r.vertex0_x = ($urandom_range(3) == 0) ? int'($urandom) : rand_coord();
    r.vertex0_y = ($urandom_range(3) == 0) ? int'($urandom) : rand_coord();
    r.vertex0_z = ($urandom_range(3) == 0) ? int'($urandom) : rand_coord();
    r.vertex1_x = r.vertex0_x + rand_coord();
    r.vertex1_y = r.vertex0_y + rand_coord();
    r.vertex1_z = r.vertex0_z + rand_coord();
    r.vertex2_x = r.vertex0_x + rand_coord();
    r.vertex2_y = r.vertex0_y + rand_coord();
    r.vertex2_z = r.vertex0_z + rand_coord();
    if (pick >= 85) begin
      // collinear or repeated vertex
      r.vertex2_x = r.vertex1_x + (r.vertex1_x - r.vertex0_x);
      r.vertex2_y = r.vertex1_y + (r.vertex1_y - r.vertex0_y);
      r.vertex2_z = r.vertex1_z + (r.vertex1_z - r.vertex0_z);
      if ($urandom_range(1)) {r.vertex1_x, r.vertex1_y, r.vertex1_z} =
                             {r.vertex0_x, r.vertex0_y, r.vertex0_z};
    end
    a = '{longint'(r.vertex0_x), longint'(r.vertex0_y), longint'(r.vertex0_z)};
    b = '{longint'(r.vertex1_x), longint'(r.vertex1_y), longint'(r.vertex1_z)};
    c = '{longint'(r.vertex2_x), longint'(r.vertex2_y), longint'(r.vertex2_z)};
    n = sb.face_normal(a, b, c);
    if (pick >= 80) begin
      if (pick < 85) n = '{0, 0, 0};
      else return r;
    end else if (pick >= 70) begin
      return r;
    end else if (pick >= 35 && pick < 60) begin
      n = '{-n[0], -n[1], -n[2]};
    end else if (pick >= 60) begin
      for (int i = 0; i < 3; i++) n[i] = n[i] + (int'($urandom) >>> $urandom_range(12, 31));
    end
    if ($urandom_range(3) == 0)
      for (int i = 0; i < 3; i++) n[i] = n[i] >>> $urandom_range(0, 20);
    r.normal_in_x = n[0][31:0];
    r.normal_in_y = n[1][31:0];
    r.normal_in_z = n[2][31:0];
    return r;
  endfunction

  task run_directed();
    tnc_in_t r;
    r = {12{32'h7FFF_FFFF}};
    send_request(r);
    r = {12{32'h8000_0000}};
    send_request(r);
    r = '0;
    send_request(r);
    r = {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
         32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
         32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    send_request(r);
    // unit triangle in the xy plane: aligned, reversed, tiny, missing, perpendicular, degenerate
    r = '0;
    r.vertex1_x = 32'sh0001_0000;
    r.vertex2_y = 32'sh0001_0000;
    r.normal_in_z = 32'sh4000_0000;
    send_request(r);
    r.normal_in_z = -32'sh4000_0000;
    send_request(r);
    r.normal_in_z = 32'sh0000_0001;
    send_request(r);
    r.normal_in_z = '0;
    send_request(r);
    r.normal_in_x = 32'sh4000_0000;
    r.normal_in_z = '0;
    send_request(r);
    r.vertex2_y = '0;
    r.vertex2_x = 32'sh0002_0000;
    send_request(r);
    r.normal_in_x = '0;
    send_request(r);
    r = {32'h0, 32'h0, 32'h4000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0,
         32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
    send_request(r);
    for (int i = 0; i < 8; i++) send_request(build_triangle());
  endtask

  initial begin
    logic [31:0] zl[5], al[5];
    int          si[5], ri[5];
    zl = '{32'h0, 32'h4000_0000, 32'h8000_29F1, $urandom_range(32'h4000_0000), 32'd10737};
    al = '{32'h0, 32'h4000_0000, 32'h0001_0000, $urandom_range(32'h0010_0000), 32'hFFFF_FFFF};
    si = '{21, 47, 0, 0, 0};
    ri = '{47, 21, 0, 0, 0};
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    send_idle    = 21;
    recv_idle    = 47;
    stall_cnt    = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    run_directed();
    drain();
    for (int p = 0; p < 5; p++) begin
      write_limit(ADDR_ZERO_LIMIT, zl[p]);
      write_limit(ADDR_ALIGN_LIMIT, al[p]);
      send_idle = si[p];
      recv_idle = ri[p];
      for (int i = 0; i < 230; i++) send_request(build_triangle());
      drain();
    end
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/tnc_pkg.sv
src/tnc_if.sv
src/tnc_face_normal.sv
src/tnc_unit_vec.sv
src/tnc_judge.sv
src/triangle_normal_checker_unit.sv
tb/triangle_normal_checker_unit_tb.sv
